[rtl/core/chcm_pkg.sv]
// Shared types and constants for the chained hash counting multiset.
`default_nettype none
package chcm_pkg;

   localparam int MAX_BUCKETS  = 1024;
   localparam int RECORD_SLOTS = 1024;
   localparam int COUNT_BITS   = 16;

   localparam int KEY_W = 31;
   localparam int CNT_W = COUNT_BITS;
   localparam int BKT_W = $clog2(MAX_BUCKETS);
   localparam int IDX_W = $clog2(RECORD_SLOTS);
   localparam int LINK_W = IDX_W + 1;
   localparam int CFG_W = 11;
   localparam int STEP_W = $clog2(KEY_W);

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(RECORD_SLOTS);
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [CNT_W-1:0]  count;
      logic [LINK_W-1:0] link;
   } rec_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_HEAD,
      S_WALK,
      S_END,
      S_LINK,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

[rtl/core/chcm_ram.sv]
// Simple dual-port synchronous RAM with a registered read.
`default_nettype none
module chcm_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/core/chcm_mod.sv]
// Bit-serial restoring remainder unit: key modulo bucket count, one bit a cycle.
`default_nettype none
module chcm_mod (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [chcm_pkg::KEY_W-1:0] dividend,
   input  wire logic [chcm_pkg::CFG_W-1:0] divisor,
   output logic                          done,
   output logic      [chcm_pkg::BKT_W-1:0] rem
);
   import chcm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [KEY_W-1:0]  dvd_ff, dvd_in;
   logic [CFG_W-1:0]  dvs_ff, dvs_in;
   logic [BKT_W-1:0]  rem_ff, rem_in;
   logic [CFG_W-1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[KEY_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[KEY_W-2:0], 1'b0};
         // The partial remainder stays below the divisor, so it fits the bucket width.
         if (trial >= dvs_ff) begin
            rem_in = BKT_W'(trial - dvs_ff);
         end else begin
            rem_in = BKT_W'(trial);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

[rtl/core/chained_hash_counting_multiset_unit.sv]
// Top level: hash table of counted records with chained buckets.
// Flow: a beat goes through S_HASH and S_HEAD, then S_WALK once per record read
// in the chain; a miss adds S_END, linking behind a tail also S_LINK; the unused
// op goes straight to S_DONE. Throughput: one beat at a time.
// Reset: synchronous; a clearing pass then empties every bucket head, taking no
// request beat. Record memory is not cleared.
`default_nettype none
module chained_hash_counting_multiset_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_op,
   input  wire logic [chcm_pkg::KEY_W-1:0]   req_key,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_found,
   output logic      [chcm_pkg::CNT_W-1:0]   rsp_count,
   output logic      [1:0]                   rsp_status,
   input  wire logic                         csr_wr_en,
   input  wire logic [chcm_pkg::CFG_W-1:0]   csr_wr_data
);
   import chcm_pkg::*;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  bcount_ff;
   logic [CFG_W-1:0]  bcount_eff;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   logic [1:0]        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic              tail_v_ff, tail_v_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   rec_type           tail_rec_ff, tail_rec_in;
   logic              free_v_ff, free_v_in;
   logic [IDX_W-1:0]  free_ff, free_in;
   logic [LINK_W-1:0] free_link_ff, free_link_in;
   logic [LINK_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic              res_found_ff, res_found_in;
   logic [CNT_W-1:0]  res_count_ff, res_count_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              mod_done;
   logic [BKT_W-1:0]  mod_rem;
   logic              head_we;
   logic [BKT_W-1:0]  head_waddr;
   logic [LINK_W-1:0] head_wdata;
   logic [LINK_W-1:0] head_rdata;
   logic              rec_we;
   logic [IDX_W-1:0]  rec_waddr;
   rec_type           rec_wdata;
   logic [IDX_W-1:0]  rec_raddr;
   logic [$bits(rec_type)-1:0] rec_rraw;
   rec_type           rd;
   logic              key_hit;
   logic              live_hit;
   logic              next_ok;
   logic              head_ok;
   logic              out_free;

   always_comb begin
      if (bcount_ff == '0) begin
         bcount_eff = CFG_W'(1);
      end else if (bcount_ff > CFG_W'(MAX_BUCKETS)) begin
         bcount_eff = CFG_W'(MAX_BUCKETS);
      end else begin
         bcount_eff = bcount_ff;
      end
   end

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign rd       = rec_type'(rec_rraw);
   assign key_hit  = (rd.key == key_ff);
   assign live_hit = key_hit && (rd.count != '0);
   assign next_ok  = (rd.link < NULL_LINK);
   assign head_ok  = (head_rdata < NULL_LINK);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   chcm_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && (req_op != OP_UNUSED)),
      .dividend (req_key),
      .divisor  (bcount_eff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   chcm_ram #(.DATA_W(LINK_W), .ADDR_W(BKT_W)) u_heads (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (mod_rem),
      .rd_data (head_rdata)
   );

   chcm_ram #(.DATA_W($bits(rec_type)), .ADDR_W(IDX_W)) u_records (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rraw)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_UNUSED) ? S_DONE : S_HASH;
            end
         end
         S_HASH: if (mod_done) state_in = S_HEAD;
         S_HEAD: state_in = head_ok ? S_WALK : S_END;
         S_WALK: begin
            if ((op_ff == OP_INSERT) ? key_hit : live_hit) begin
               state_in = S_DONE;
            end else if (!next_ok) begin
               state_in = S_END;
            end
         end
         S_END: begin
            if (op_ff == OP_INSERT && !free_v_ff && used_ff != NULL_LINK && tail_v_ff) begin
               state_in = S_LINK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LINK: state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      bucket_in     = bucket_ff;
      tail_v_in     = tail_v_ff;
      tail_in       = tail_ff;
      tail_rec_in   = tail_rec_ff;
      free_v_in     = free_v_ff;
      free_in       = free_ff;
      free_link_in  = free_link_ff;
      used_in       = used_ff;
      cur_in        = cur_ff;
      res_found_in  = res_found_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      head_we       = 1'b0;
      head_waddr    = bucket_ff;
      head_wdata    = NULL_LINK;
      rec_we        = 1'b0;
      rec_waddr     = cur_ff;
      rec_wdata     = rd;
      rec_raddr     = rd.link[IDX_W-1:0];
      req_stall     = (state_ff != S_IDLE);

      case (state_ff)
         S_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               key_in        = req_key;
               tail_v_in     = 1'b0;
               free_v_in     = 1'b0;
               res_found_in  = 1'b0;
               res_count_in  = '0;
               res_status_in = ST_DONE;
            end
         end
         S_HASH: bucket_in = mod_rem;
         S_HEAD: begin
            rec_raddr = head_rdata[IDX_W-1:0];
            cur_in    = head_rdata[IDX_W-1:0];
         end
         S_WALK: begin
            cur_in = rd.link[IDX_W-1:0];
            if (op_ff == OP_INSERT) begin
               if (key_hit) begin
                  rec_we       = 1'b1;
                  res_found_in = (rd.count != '0);
                  if (rd.count != COUNT_MAX) begin
                     rec_wdata.count = rd.count + 1'b1;
                  end
                  res_count_in = rec_wdata.count;
               end else begin
                  if (rd.count == '0 && !free_v_ff) begin
                     free_v_in    = 1'b1;
                     free_in      = cur_ff;
                     free_link_in = rd.link;
                  end
                  tail_v_in   = 1'b1;
                  tail_in     = cur_ff;
                  tail_rec_in = rd;
               end
            end else if (live_hit) begin
               res_found_in = 1'b1;
               res_count_in = rd.count;
               if (op_ff == OP_REMOVE) begin
                  rec_we          = 1'b1;
                  rec_wdata.count = rd.count - 1'b1;
                  res_count_in    = rec_wdata.count;
               end
            end
         end
         S_END: begin
            rec_wdata.key   = key_ff;
            rec_wdata.count = CNT_W'(1);
            if (op_ff != OP_INSERT) begin
               res_status_in = ST_ABSENT;
            end else if (free_v_ff) begin
               // Reuse an emptied record in place and keep its link.
               rec_we         = 1'b1;
               rec_waddr      = free_ff;
               rec_wdata.link = free_link_ff;
               res_count_in   = CNT_W'(1);
            end else if (used_ff == NULL_LINK) begin
               res_status_in = ST_FULL;
            end else begin
               rec_we         = 1'b1;
               rec_waddr      = used_ff[IDX_W-1:0];
               rec_wdata.link = NULL_LINK;
               res_count_in   = CNT_W'(1);
               used_in        = used_ff + 1'b1;
               cur_in         = used_ff[IDX_W-1:0];
               if (!tail_v_ff) begin
                  head_we    = 1'b1;
                  head_wdata = used_ff;
               end
            end
         end
         S_LINK: begin
            rec_we         = 1'b1;
            rec_waddr      = tail_ff;
            rec_wdata      = tail_rec_ff;
            rec_wdata.link = {1'b0, cur_ff};
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_count_in  = res_count_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         bcount_ff    <= CFG_W'(MAX_BUCKETS);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bcount_ff <= csr_wr_data;
         end
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      bucket_ff     <= bucket_in;
      tail_v_ff     <= tail_v_in;
      tail_ff       <= tail_in;
      tail_rec_ff   <= tail_rec_in;
      free_v_ff     <= free_v_in;
      free_ff       <= free_in;
      free_link_ff  <= free_link_in;
      cur_ff        <= cur_in;
      res_found_ff  <= res_found_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

[rtl/core/chcm_check.sv]
// Port-level checks for the multiset unit, bound to the top level.
`default_nettype none
module chcm_check (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic                       rsp_found,
   input wire logic [chcm_pkg::CNT_W-1:0] rsp_count,
   input wire logic [1:0]                 rsp_status
);
   import chcm_pkg::*;

   // A held result beat stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A miss or a full store reports no hit and a zero count.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ABSENT || rsp_status == ST_FULL)
      |-> !rsp_found && rsp_count == '0)
      else $error("miss or full beat carries a hit or a count");

   // A hit always completes with a done status; its count is nonzero except after removing the last one.
   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_DONE)
      else $error("hit reported with an error status");

   // A completed beat without a prior hit is a fresh insert or a no-op.
   a_fresh_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found && rsp_status == ST_DONE |-> rsp_count <= CNT_W'(1))
      else $error("fresh insert with a count above one");

   a_no_rsp_in_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind chained_hash_counting_multiset_unit chcm_check u_chcm_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_found  (rsp_found),
   .rsp_count  (rsp_count),
   .rsp_status (rsp_status)
);
`default_nettype wire

[bench/chained_hash_counting_multiset_unit_test.sv]
// Self-checking testbench for the chained hash counting multiset unit.
module chained_hash_counting_multiset_unit_test;
   import chcm_pkg::*;

   localparam int PERIOD = 12;

   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] count;
      logic [1:0]       status;
   } tally_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = OP_INSERT;
   logic [KEY_W-1:0] req_key = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [CNT_W-1:0] rsp_count;
   logic [1:0] rsp_status;
   logic csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   chained_hash_counting_multiset_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_count(rsp_count), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Shadow copy of the table, updated as each beat is offered.
   logic [CFG_W-1:0]  shadow_buckets;
   logic [LINK_W-1:0] shadow_heads [MAX_BUCKETS];
   logic [KEY_W-1:0]  shadow_keys  [RECORD_SLOTS];
   logic [CNT_W-1:0]  shadow_counts[RECORD_SLOTS];
   logic [LINK_W-1:0] shadow_links [RECORD_SLOTS];
   int                shadow_used;

   tally_type pending_tallies[$];
   int errors = 0;
   int beats_sent = 0;
   int tallies_checked = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int stall_left = 0;
   logic [KEY_W-1:0] key_pool[16];

   initial forever #(PERIOD / 2) clock = ~clock;

   initial begin
      #(64'd20_000_000 * PERIOD);
      $display("Timeout with %0d results outstanding", pending_tallies.size());
      $display("FAILURE");
      $finish;
   end

   function automatic int bucket_of(logic [KEY_W-1:0] key);
      int m;
      m = int'(shadow_buckets);
      if (m == 0) m = 1;
      if (m > MAX_BUCKETS) m = MAX_BUCKETS;
      return int'(key % m);
   endfunction

   function automatic tally_type apply_op(logic [1:0] op, logic [KEY_W-1:0] key);
      tally_type t;
      int b, r, tail, spare, steps;
      t = '0;
      b = bucket_of(key);
      r = int'(shadow_heads[b]);
      tail = RECORD_SLOTS;
      spare = RECORD_SLOTS;
      steps = 0;
      if (op == OP_INSERT) begin
         while (r < RECORD_SLOTS && steps < RECORD_SLOTS) begin
            if (shadow_keys[r] == key) begin
               t.found = (shadow_counts[r] != '0);
               if (shadow_counts[r] != COUNT_MAX) shadow_counts[r]++;
               t.count = shadow_counts[r];
               return t;
            end
            if (shadow_counts[r] == '0 && spare == RECORD_SLOTS) spare = r;
            tail = r;
            r = int'(shadow_links[r]);
            steps++;
         end
         if (spare != RECORD_SLOTS) begin
            shadow_keys[spare] = key;
            shadow_counts[spare] = CNT_W'(1);
            t.count = CNT_W'(1);
         end else if (shadow_used >= RECORD_SLOTS) begin
            t.status = ST_FULL;
         end else begin
            r = shadow_used;
            shadow_used++;
            shadow_keys[r] = key;
            shadow_counts[r] = CNT_W'(1);
            shadow_links[r] = NULL_LINK;
            if (tail < RECORD_SLOTS) shadow_links[tail] = LINK_W'(r);
            else shadow_heads[b] = LINK_W'(r);
            t.count = CNT_W'(1);
         end
      end else if (op == OP_REMOVE || op == OP_SEARCH) begin
         while (r < RECORD_SLOTS && steps < RECORD_SLOTS) begin
            if (shadow_keys[r] == key && shadow_counts[r] != '0) break;
            r = int'(shadow_links[r]);
            steps++;
         end
         if (r < RECORD_SLOTS && steps < RECORD_SLOTS) begin
            if (op == OP_REMOVE) shadow_counts[r]--;
            t.found = 1'b1;
            t.count = shadow_counts[r];
         end else begin
            t.status = ST_ABSENT;
         end
      end
      return t;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("Mismatch on result %0d: %s is %0d, expected %0d", tallies_checked, what,
         got, want);
   endtask

   // Offers one beat, with an optional gap first, and returns at the edge that takes it.
   task automatic send_item(logic [1:0] op, logic [KEY_W-1:0] key);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_key <= key;
      pending_tallies.push_back(apply_op(op, key));
      beats_sent++;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_tallies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_buckets(logic [CFG_W-1:0] value);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_buckets = value;
   endtask

   function automatic logic [KEY_W-1:0] any_key();
      return KEY_W'($urandom);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 15)];
      return any_key();
   endfunction

   function automatic logic [1:0] pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return OP_INSERT;
      if (roll < 70) return OP_REMOVE;
      if (roll < 95) return OP_SEARCH;
      return OP_UNUSED;
   endfunction

   // Checks each result beat as it is taken.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tallies.size() == 0) begin
            errors++;
            $display("Unexpected result beat: found %0d count %0d status %0d",
               rsp_found, rsp_count, rsp_status);
         end else begin
            if (rsp_found !== pending_tallies[0].found)
               report_mismatch("found", rsp_found, pending_tallies[0].found);
            if (rsp_count !== pending_tallies[0].count)
               report_mismatch("count", rsp_count, pending_tallies[0].count);
            if (rsp_status !== pending_tallies[0].status)
               report_mismatch("status", rsp_status, pending_tallies[0].status);
            void'(pending_tallies.pop_front());
         end
         tallies_checked++;
      end
   end

   // Drives the result-side stall: short random bursts, or one long hold on request.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         stall_left <= 400;
         hold_done <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_empty_table();
      send_item(OP_SEARCH, 31'd0);
      send_item(OP_REMOVE, '1);
      send_item(OP_UNUSED, 31'd77);
      send_item(OP_INSERT, 31'd0);
      send_item(OP_INSERT, '1);
      send_item(OP_INSERT, '1);
      send_item(OP_SEARCH, '1);
      send_item(OP_UNUSED, '1);
      send_item(OP_REMOVE, '1);
      send_item(OP_REMOVE, '1);
      send_item(OP_SEARCH, '1);
      send_item(OP_REMOVE, '1);
   endtask

   task automatic test_record_reuse();
      // A key whose count fell to zero is revived in place.
      send_item(OP_INSERT, 31'd20);
      send_item(OP_REMOVE, 31'd20);
      send_item(OP_INSERT, 31'd20);
      // A zero-count record is taken over by another key of the same bucket.
      send_item(OP_INSERT, 31'd10);
      send_item(OP_REMOVE, 31'd10);
      send_item(OP_INSERT, 31'd1034);
      send_item(OP_SEARCH, 31'd10);
      send_item(OP_INSERT, 31'd10);
      send_item(OP_INSERT, 31'd2058);
      send_item(OP_SEARCH, 31'd2058);
   endtask

   task automatic test_repeat_count();
      idle_on = 1'b0;
      repeat (40) send_item(OP_INSERT, 31'd5);
      send_item(OP_SEARCH, 31'd5);
      send_item(OP_REMOVE, 31'd5);
      idle_on = 1'b1;
   endtask

   task automatic test_random_phase(logic [CFG_W-1:0] buckets, int beats);
      set_buckets(buckets);
      foreach (key_pool[i])
         key_pool[i] = (i < 8) ? KEY_W'($urandom_range(0, 63)) : any_key();
      repeat (beats) send_item(pick_op(), pick_key());
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      while (!hold_done) @(posedge clock);
      repeat (30) send_item(pick_op(), pick_key());
   endtask

   task automatic test_store_full();
      set_buckets(CFG_W'(MAX_BUCKETS));
      while (shadow_used < RECORD_SLOTS) send_item(OP_INSERT, any_key());
      repeat (6) send_item(OP_INSERT, any_key());
   endtask

   initial begin
      shadow_buckets = CFG_W'(MAX_BUCKETS);
      foreach (shadow_heads[i]) shadow_heads[i] = NULL_LINK;
      foreach (shadow_keys[i]) begin
         shadow_keys[i] = '0;
         shadow_counts[i] = '0;
         shadow_links[i] = '0;
      end
      shadow_used = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_record_reuse();
      test_repeat_count();
      test_random_phase(CFG_W'(0), 100);
      test_random_phase(CFG_W'(1), 100);
      test_random_phase(CFG_W'(2047), 100);
      test_random_phase(CFG_W'(7), 100);
      test_backpressure();
      test_random_phase(CFG_W'(3), 100);
      test_random_phase(CFG_W'(MAX_BUCKETS), 100);
      test_store_full();
      idle_on = 1'b0;
      test_random_phase(CFG_W'(1000), 100);

      wait_quiet();
      repeat (100) @(posedge clock);
      $display("Sent %0d beats and checked %0d results over bucket counts 0 to 2047,",
         beats_sent, tallies_checked);
      $display("including repeated inserts, record reuse, a long hold and a full store.");
      if (errors == 0 && pending_tallies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/chcm_pkg.sv
rtl/core/chcm_ram.sv
rtl/core/chcm_mod.sv
rtl/core/chained_hash_counting_multiset_unit.sv
rtl/core/chcm_check.sv
bench/chained_hash_counting_multiset_unit_test.sv
